>>> src/dcdft_pkg.sv
// ----------------------------------------------------------------------------
// dcdft_pkg
// Types and fixed constants shared by the direct complex DFT block.
// ----------------------------------------------------------------------------
package dcdft_pkg;

    localparam int SAMPLE_W    = 16;
    localparam int COEF_W      = 16;
    localparam int PROD_W      = 32;
    localparam int ACC_W       = 40;
    localparam int BIN_W       = 23;
    localparam int BIN_NUM_W   = 6;
    localparam int ROUND_SHIFT = 15;

    // Pi/2 in unsigned Q30.
    localparam longint unsigned PIH_Q30 = 64'd1686629713;

    typedef logic signed [SAMPLE_W-1:0] t_sample;
    typedef logic signed [COEF_W-1:0]   t_coef;
    typedef logic signed [PROD_W-1:0]   t_prod;
    typedef logic signed [ACC_W-1:0]    t_acc;

    typedef struct packed {
        t_sample re;
        t_sample im;
    } t_pair;

    typedef struct packed {
        logic valid;
        logic first;
        logic last;
    } t_mac_ctl;

    typedef enum logic {
        ST_LOAD,
        ST_CALC
    } t_state;

    // Clamp a Q30 value to [0, 1.0], round to Q15 and saturate +1.0.
    function automatic t_coef q30_to_q15(input longint v);
        longint          c;
        longint unsigned u;
        c = v;
        if (c < 0) begin
            c = 0;
        end
        if (c > (64'sd1 <<< 30)) begin
            c = 64'sd1 <<< 30;
        end
        u = (longint'(c) + (64'd1 << 14)) >> 15;
        if (u > 64'd32767) begin
            u = 64'd32767;
        end
        return t_coef'(u[COEF_W-1:0]);
    endfunction

endpackage

>>> src/dcdft_mac.sv
// ----------------------------------------------------------------------------
// dcdft_mac
// Shared complex multiply-accumulate unit: one sample times one twiddle
// per cycle while i_adv is high, products registered, then summed into bins.
// ----------------------------------------------------------------------------
module dcdft_mac (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_adv,
    input  dcdft_pkg::t_mac_ctl i_ctl,
    input  dcdft_pkg::t_sample  i_x_real,
    input  dcdft_pkg::t_sample  i_x_imag,
    input  dcdft_pkg::t_coef    i_coef_cos,
    input  dcdft_pkg::t_coef    i_coef_sin,
    output dcdft_pkg::t_acc     o_acc_real,
    output dcdft_pkg::t_acc     o_acc_imag,
    output logic                o_done
);

    dcdft_pkg::t_mac_ctl r_b_ctl;
    dcdft_pkg::t_prod    r_p_xr_c;
    dcdft_pkg::t_prod    r_p_xi_s;
    dcdft_pkg::t_prod    r_p_xi_c;
    dcdft_pkg::t_prod    r_p_xr_s;
    dcdft_pkg::t_acc     r_acc_re;
    dcdft_pkg::t_acc     r_acc_im;
    logic                r_done;
    dcdft_pkg::t_acc     base_re;
    dcdft_pkg::t_acc     base_im;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_ctl <= '0;
            r_done  <= 1'b0;
        end else if (i_adv) begin
            r_b_ctl <= i_ctl;
            r_done  <= r_b_ctl.valid && r_b_ctl.last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_p_xr_c <= i_x_real * i_coef_cos;
            r_p_xi_s <= i_x_imag * i_coef_sin;
            r_p_xi_c <= i_x_imag * i_coef_cos;
            r_p_xr_s <= i_x_real * i_coef_sin;
        end
    end

    // The first term of a bin restarts the sums.
    always_comb begin
        base_re = r_b_ctl.first ? '0 : r_acc_re;
        base_im = r_b_ctl.first ? '0 : r_acc_im;
    end

    always_ff @(posedge i_clk) begin
        if (i_adv && r_b_ctl.valid) begin
            r_acc_re <= base_re + dcdft_pkg::ACC_W'(r_p_xr_c)
                                + dcdft_pkg::ACC_W'(r_p_xi_s);
            r_acc_im <= base_im + dcdft_pkg::ACC_W'(r_p_xi_c)
                                - dcdft_pkg::ACC_W'(r_p_xr_s);
        end
    end

    assign o_acc_real = r_acc_re;
    assign o_acc_imag = r_acc_im;
    assign o_done     = r_done;

endmodule

>>> src/direct_complex_dft.sv
// ----------------------------------------------------------------------------
// direct_complex_dft
// Direct forward DFT of a frame of POINTS complex samples.
// ----------------------------------------------------------------------------
// Input requests carry one complex sample each; the block holds o_in_stall low
// while it loads a frame, one sample per cycle, into an internal sample store.
// The request that completes the frame starts the transform, and input is
// stalled while the shared complex MAC unit works through every (bin, sample)
// pair, one pair per cycle unless a stalled output holds the pipeline.
// Output requests carry one bin each, k = 0 .. POINTS-1, with o_final_bin set
// on the last one. Throughput is set by the single MAC, which forms every
// (bin, sample) product of the frame in turn.
// Loading of the next frame may begin as soon as the last sample-store read
// for the current frame is issued, while the final bins are still draining.
// When the receiver stalls and a finished bin cannot enter the output
// register, the whole MAC pipeline holds until the output is taken.
// Reset clears the load position and the pipeline; store contents are not
// cleared, since every entry is written before a frame is computed.
// ----------------------------------------------------------------------------
module direct_complex_dft #(
    parameter int POINTS = 64
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_in_valid,
    output logic                    o_in_stall,
    input  logic signed [15:0]      i_sample_real,
    input  logic signed [15:0]      i_sample_imag,
    output logic                    o_out_valid,
    input  logic                    i_out_stall,
    output logic [5:0]              o_bin_number,
    output logic signed [22:0]      o_bin_real,
    output logic signed [22:0]      o_bin_imag,
    output logic                    o_final_bin
);

    localparam int IW = $clog2(POINTS);
    localparam logic [IW-1:0] LAST_IDX = IW'(POINTS - 1);
    localparam logic [IW:0]   PTS_EXT  = (IW + 1)'(POINTS);
    localparam dcdft_pkg::t_acc ROUND_ADD = dcdft_pkg::ACC_W'(1 << 14);

    typedef dcdft_pkg::t_coef t_tw_tab [POINTS];

    // One Taylor step divides by (2i)(2i+1) for sine and by (2i-1)(2i) for cosine.
    function automatic longint unsigned taylor_div(input longint unsigned v,
                                                   input logic for_sin,
                                                   input int i);
        longint unsigned d;
        d = v;
        case (i)
            1: d = for_sin ? v / 64'd6   : v / 64'd2;
            2: d = for_sin ? v / 64'd20  : v / 64'd12;
            3: d = for_sin ? v / 64'd42  : v / 64'd30;
            4: d = for_sin ? v / 64'd72  : v / 64'd56;
            5: d = for_sin ? v / 64'd110 : v / 64'd90;
            6: d = for_sin ? v / 64'd156 : v / 64'd132;
            7: d = for_sin ? v / 64'd210 : v / 64'd182;
            8: d = for_sin ? v / 64'd272 : v / 64'd240;
            9: d = for_sin ? v / 64'd342 : v / 64'd306;
            default: d = v;
        endcase
        return d;
    endfunction

    // Twiddle table, cos and sin of 2*pi*m/POINTS in Q1.15, built at
    // elaboration from a quadrant fold and a Taylor series in Q30.
    function automatic t_tw_tab build_tab(input logic want_sin);
        t_tw_tab           tab;
        longint unsigned   t;
        longint unsigned   q;
        longint unsigned   r;
        longint unsigned   x;
        longint unsigned   term;
        longint            sacc;
        longint            cacc;
        dcdft_pkg::t_coef  c;
        dcdft_pkg::t_coef  s;
        dcdft_pkg::t_coef  cs;
        dcdft_pkg::t_coef  sn;
        for (int m = 0; m < POINTS; m++) begin
            // With m below POINTS the angle never passes a full turn.
            t = 64'(4 * m);
            q = t / POINTS;
            r = t % POINTS;
            x = (dcdft_pkg::PIH_Q30 * r) / POINTS;
            term = x;
            sacc = longint'(x);
            for (int i = 1; i <= 9; i++) begin
                term = (((term * x) >> 30) * x) >> 30;
                term = taylor_div(term, 1'b1, i);
                if (i % 2 == 1) begin
                    sacc = sacc - longint'(term);
                end else begin
                    sacc = sacc + longint'(term);
                end
            end
            term = 64'd1 << 30;
            cacc = longint'(term);
            for (int i = 1; i <= 9; i++) begin
                term = (((term * x) >> 30) * x) >> 30;
                term = taylor_div(term, 1'b0, i);
                if (i % 2 == 1) begin
                    cacc = cacc - longint'(term);
                end else begin
                    cacc = cacc + longint'(term);
                end
            end
            c = dcdft_pkg::q30_to_q15(cacc);
            s = dcdft_pkg::q30_to_q15(sacc);
            case (q)
                64'd0: begin
                    cs = c;
                    sn = s;
                end
                64'd1: begin
                    cs = -s;
                    sn = c;
                end
                64'd2: begin
                    cs = -c;
                    sn = -s;
                end
                default: begin
                    cs = s;
                    sn = -c;
                end
            endcase
            tab[m] = want_sin ? sn : cs;
        end
        return tab;
    endfunction

    localparam t_tw_tab COS_TAB = build_tab(1'b0);
    localparam t_tw_tab SIN_TAB = build_tab(1'b1);

    dcdft_pkg::t_state   r_state;
    dcdft_pkg::t_state   n_state;
    logic [IW-1:0]       r_load_cnt;
    logic [IW-1:0]       r_n;
    logic [IW-1:0]       r_k;
    logic [IW-1:0]       r_m;
    logic [IW-1:0]       n_m;
    logic [IW:0]         m_sum;
    dcdft_pkg::t_pair    r_mem [POINTS];
    dcdft_pkg::t_pair    r_a_x;
    dcdft_pkg::t_coef    r_a_cos;
    dcdft_pkg::t_coef    r_a_sin;
    dcdft_pkg::t_mac_ctl r_a_ctl;
    dcdft_pkg::t_acc     acc_re;
    dcdft_pkg::t_acc     acc_im;
    dcdft_pkg::t_acc     rnd_re;
    dcdft_pkg::t_acc     rnd_im;
    logic                mac_done;
    logic                adv;
    logic                load_out;
    logic                in_ready;
    logic                in_acc;
    logic                issue;
    logic                r_out_valid;
    logic [IW-1:0]       r_bin_cnt;
    logic [5:0]          r_bin_number;
    logic signed [22:0]  r_bin_real;
    logic signed [22:0]  r_bin_imag;
    logic                r_final_bin;

    // The pipeline holds only when a finished bin meets a stalled output.
    assign adv      = !(mac_done && r_out_valid && i_out_stall);
    assign load_out = mac_done && adv;
    assign in_acc   = i_in_valid && in_ready;

    always_comb begin
        n_state = r_state;
        case (r_state)
            dcdft_pkg::ST_LOAD: begin
                if (in_acc && r_load_cnt == LAST_IDX) begin
                    n_state = dcdft_pkg::ST_CALC;
                end
            end
            dcdft_pkg::ST_CALC: begin
                if (adv && r_n == LAST_IDX && r_k == LAST_IDX) begin
                    n_state = dcdft_pkg::ST_LOAD;
                end
            end
            default: n_state = dcdft_pkg::ST_LOAD;
        endcase
    end

    always_comb begin
        in_ready = 1'b0;
        issue    = 1'b0;
        case (r_state)
            dcdft_pkg::ST_LOAD: in_ready = 1'b1;
            dcdft_pkg::ST_CALC: issue    = adv;
            default: begin
                in_ready = 1'b0;
                issue    = 1'b0;
            end
        endcase
    end

    assign o_in_stall = !in_ready;

    // Twiddle index m = n*k mod POINTS, stepped by k along each bin.
    always_comb begin
        m_sum = {1'b0, r_m} + {1'b0, r_k};
        if (m_sum >= PTS_EXT) begin
            m_sum = m_sum - PTS_EXT;
        end
        n_m = m_sum[IW-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= dcdft_pkg::ST_LOAD;
            r_load_cnt <= '0;
            r_n        <= '0;
            r_k        <= '0;
            r_m        <= '0;
        end else begin
            r_state <= n_state;
            if (in_acc) begin
                r_load_cnt <= (r_load_cnt == LAST_IDX) ? '0 : r_load_cnt + 1'b1;
            end
            if (issue) begin
                if (r_n == LAST_IDX) begin
                    r_n <= '0;
                    r_m <= '0;
                    r_k <= (r_k == LAST_IDX) ? '0 : r_k + 1'b1;
                end else begin
                    r_n <= r_n + 1'b1;
                    r_m <= n_m;
                end
            end
        end
    end

    // Sample store: written while loading, read once per MAC step.
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_mem[r_load_cnt] <= '{re: i_sample_real, im: i_sample_imag};
        end
        if (issue) begin
            r_a_x   <= r_mem[r_n];
            r_a_cos <= COS_TAB[r_m];
            r_a_sin <= SIN_TAB[r_m];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_ctl <= '0;
        end else if (adv) begin
            r_a_ctl <= '{valid: issue, first: (r_n == '0), last: (r_n == LAST_IDX)};
        end
    end

    dcdft_mac u_mac (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_adv      (adv),
        .i_ctl      (r_a_ctl),
        .i_x_real   (r_a_x.re),
        .i_x_imag   (r_a_x.im),
        .i_coef_cos (r_a_cos),
        .i_coef_sin (r_a_sin),
        .o_acc_real (acc_re),
        .o_acc_imag (acc_im),
        .o_done     (mac_done)
    );

    // Round half up: add 2^14, then an arithmetic shift by 15.
    assign rnd_re = acc_re + ROUND_ADD;
    assign rnd_im = acc_im + ROUND_ADD;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_bin_cnt   <= '0;
        end else if (load_out) begin
            r_out_valid <= 1'b1;
            r_bin_cnt   <= (r_bin_cnt == LAST_IDX) ? '0 : r_bin_cnt + 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load_out) begin
            r_bin_number <= 6'(r_bin_cnt);
            r_bin_real   <= rnd_re[dcdft_pkg::ROUND_SHIFT +: dcdft_pkg::BIN_W];
            r_bin_imag   <= rnd_im[dcdft_pkg::ROUND_SHIFT +: dcdft_pkg::BIN_W];
            r_final_bin  <= (r_bin_cnt == LAST_IDX);
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_bin_number = r_bin_number;
    assign o_bin_real   = r_bin_real;
    assign o_bin_imag   = r_bin_imag;
    assign o_final_bin  = r_final_bin;

    a_hold_only_on_stall : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !adv |-> (r_out_valid && i_out_stall))
        else $error("MAC pipeline held without a stalled output");

    a_frame_starts_calc : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && r_load_cnt == LAST_IDX) |=> (r_state == dcdft_pkg::ST_CALC))
        else $error("full frame did not start the transform");

    a_calc_ends_clean : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (issue && r_n == LAST_IDX && r_k == LAST_IDX)
        |=> (r_state == dcdft_pkg::ST_LOAD && r_k == '0 && r_n == '0))
        else $error("transform did not end with counters cleared");

    a_final_is_last_bin : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_final_bin) |-> (o_bin_number == 6'(LAST_IDX)))
        else $error("final flag on a bin other than the last");

endmodule
